// ===== sv/half_step_stepper_sequencer_unit_assert.svh =====
// assertion macros for the half-step stepper sequencer
// all checks are sampled on the rising edge of clk and held off while rst_n is low
`ifndef HALF_STEP_STEPPER_SEQUENCER_UNIT_ASSERT_SVH
`define HALF_STEP_STEPPER_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define HSSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HSSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/hssu_pkg.sv =====
// ----------------------------------------------------------------------------
// hssu_pkg
// Types, constants and coil pattern tables for the half-step stepper sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hssu_pkg;

  // field widths
  localparam int ANGLE_BITS      = 16;
  localparam int DELAY_W         = 8;
  localparam int PHASE_W         = 3;
  localparam int COIL_W          = 4;
  localparam int BEAT_W          = 19;

  // beat scaling: beats = |angle| * BEATS_PER_REV / DEGREES_PER_REV
  localparam int BEATS_PER_REV   = 4096;
  localparam int DEGREES_PER_REV = 360;

  // exact reciprocal: floor(m * 4096 / 360) == (m * RECIP) >> RECIP_SHIFT for m < 2^16
  localparam int RECIP_W         = 25;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(23860930);
  localparam int RECIP_SHIFT     = 21;
  localparam int PROD_W          = ANGLE_BITS + RECIP_W;
  localparam int QUOT_W          = PROD_W - RECIP_SHIFT;

  localparam logic [BEAT_W-1:0] BEATS_MAX = '1;
  localparam logic [BEAT_W-1:0] BEATS_ONE = BEAT_W'(1);

  typedef enum logic [1:0] {
    REQ_MOVE = 2'd0,
    REQ_TICK = 2'd1,
    REQ_STOP = 2'd2,
    REQ_NOP  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    DIR_NONE_LO = 2'd0,
    DIR_FWD     = 2'd1,
    DIR_REV     = 2'd2,
    DIR_NONE_HI = 2'd3
  } dir_t;

  // forward half-step pattern for a phase
  function automatic logic [COIL_W-1:0] fwd_pattern(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] p;
    unique case (ph)
      3'd0:    p = 4'h7;
      3'd1:    p = 4'h3;
      3'd2:    p = 4'hB;
      3'd3:    p = 4'h9;
      3'd4:    p = 4'hD;
      3'd5:    p = 4'hC;
      3'd6:    p = 4'hE;
      default: p = 4'h6;
    endcase
    return p;
  endfunction

  // rollback pattern: forward table read back to front
  function automatic logic [COIL_W-1:0] rev_pattern(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] p;
    unique case (ph)
      3'd0:    p = 4'h6;
      3'd1:    p = 4'hE;
      3'd2:    p = 4'hC;
      3'd3:    p = 4'hD;
      3'd4:    p = 4'h9;
      3'd5:    p = 4'hB;
      3'd6:    p = 4'h3;
      default: p = 4'h7;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/hssu_beat_calc.sv =====
// ----------------------------------------------------------------------------
// hssu_beat_calc
// Turns a signed angle into a beat count: magnitude, reciprocal multiply by
// 4096/360, saturation, and the single-step override.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hssu_beat_calc
  import hssu_pkg::*;
(
  input  logic signed [ANGLE_BITS-1:0] angle,
  input  logic                         single_step,
  output logic        [BEAT_W-1:0]     beats
);

  logic [ANGLE_BITS-1:0] mag;
  logic [PROD_W-1:0]     prod;
  logic [QUOT_W-1:0]     quot;

  // two's complement magnitude; the most negative value maps onto its own bit pattern
  assign mag = angle[ANGLE_BITS-1] ? (~angle + ANGLE_BITS'(1)) : angle;

  // divide by 360 through an exact reciprocal
  assign prod = PROD_W'(mag) * PROD_W'(RECIP);
  assign quot = prod[PROD_W-1:RECIP_SHIFT];

  // saturate, then apply the single-step override
  always_comb begin
    if (single_step) begin
      beats = BEATS_ONE;
    end else if (quot > QUOT_W'(BEATS_MAX)) begin
      beats = BEATS_MAX;
    end else begin
      beats = quot[BEAT_W-1:0];
    end
  end

endmodule

// ===== sv/half_step_stepper_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// half_step_stepper_sequencer_unit
// An accepted transaction passes through stage 1 and stage 2 to its result on out_*.
// Throughput: one transaction per cycle unless out_stall holds; stage 1 holds the beat multiply,
// stage 2 updates the sequencer state and the result register.
// Reset: synchronous active-low rst_n empties both stages, zeroes the phase,
// beats, wait, delay and direction, and turns all coils off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module half_step_stepper_sequencer_unit
  import hssu_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_req_type,
  input  logic [1:0]                   in_direction_code,
  input  logic [DELAY_W-1:0]           in_step_delay,
  input  logic signed [ANGLE_BITS-1:0] in_angle_degrees,
  input  logic                         in_single_step,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [COIL_W-1:0]            out_coil_lines,
  output logic                         out_stepped,
  output logic                         out_busy_res
);

  // stage 1 registers
  logic               s1_valid_r;
  req_t               s1_req_r;
  dir_t               s1_dir_r;
  logic [DELAY_W-1:0] s1_delay_r;
  logic [BEAT_W-1:0]  s1_beats_r;

  // sequencer state
  logic [PHASE_W-1:0] phase_r,  phase_nxt;
  logic [BEAT_W-1:0]  beats_r,  beats_nxt;
  logic [DELAY_W-1:0] wait_r,   wait_nxt;
  logic [DELAY_W-1:0] delay_r,  delay_nxt;
  logic               rev_r,    rev_nxt;
  logic [COIL_W-1:0]  coil_r,   coil_nxt;
  logic               stepped_nxt;

  // result register
  logic               out_valid_r;
  logic [COIL_W-1:0]  out_coil_r;
  logic               out_stepped_r;
  logic               out_busy_r;

  logic [BEAT_W-1:0]  calc_beats;
  logic [DELAY_W-1:0] wait_dec;
  logic [PHASE_W-1:0] phase_inc;
  logic               out_load;
  logic               s1_adv;
  logic               in_acc;

  // handshake: result register frees up when empty or taken
  assign out_load = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;
  assign in_acc   = in_valid && !in_stall;

  hssu_beat_calc u_beat_calc (
    .angle       (in_angle_degrees),
    .single_step (in_single_step),
    .beats       (calc_beats)
  );

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r   <= req_t'(in_req_type);
      s1_dir_r   <= dir_t'(in_direction_code);
      s1_delay_r <= in_step_delay;
      s1_beats_r <= calc_beats;
    end
  end

  // sequencer update for the transaction leaving stage 1
  assign wait_dec  = (wait_r != '0) ? (wait_r - DELAY_W'(1)) : wait_r;
  assign phase_inc = phase_r + PHASE_W'(1);

  always_comb begin
    phase_nxt   = phase_r;
    beats_nxt   = beats_r;
    wait_nxt    = wait_r;
    delay_nxt   = delay_r;
    rev_nxt     = rev_r;
    coil_nxt    = coil_r;
    stepped_nxt = 1'b0;
    unique case (s1_req_r)
      REQ_MOVE: begin
        wait_nxt = '0;
        if (s1_dir_r == DIR_FWD || s1_dir_r == DIR_REV) begin
          beats_nxt = s1_beats_r;
          delay_nxt = s1_delay_r;
          rev_nxt   = (s1_dir_r == DIR_REV);
        end else begin
          beats_nxt = '0;
        end
      end
      REQ_TICK: begin
        wait_nxt = wait_dec;
        if (wait_dec == '0 && beats_r != '0) begin
          phase_nxt   = phase_inc;
          coil_nxt    = rev_r ? rev_pattern(phase_inc) : fwd_pattern(phase_inc);
          beats_nxt   = beats_r - BEAT_W'(1);
          wait_nxt    = delay_r;
          stepped_nxt = 1'b1;
        end
      end
      REQ_STOP: begin
        beats_nxt = '0;
        wait_nxt  = '0;
        coil_nxt  = '0;
      end
      REQ_NOP: begin
        stepped_nxt = 1'b0;
      end
      default: begin
        stepped_nxt = 1'b0;
      end
    endcase
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      beats_r <= '0;
      wait_r  <= '0;
      delay_r <= '0;
      rev_r   <= 1'b0;
      coil_r  <= '0;
    end else if (s1_adv) begin
      phase_r <= phase_nxt;
      beats_r <= beats_nxt;
      wait_r  <= wait_nxt;
      delay_r <= delay_nxt;
      rev_r   <= rev_nxt;
      coil_r  <= coil_nxt;
    end
  end

  // result control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_coil_r    <= coil_nxt;
      out_stepped_r <= stepped_nxt;
      out_busy_r    <= (beats_nxt != '0) || (wait_nxt != '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_coil_lines = out_coil_r;
  assign out_stepped    = out_stepped_r;
  assign out_busy_res   = out_busy_r;

  // checks
  `include "half_step_stepper_sequencer_unit_assert.svh"

  `HSSU_ASSERT_IMP(a_step_drives_coils, out_valid_r && out_stepped_r, out_coil_r != '0, "step result with coils off")
  `HSSU_ASSERT_NXT(a_stop_clears, s1_adv && s1_req_r == REQ_STOP, coil_r == '0 && beats_r == '0 && wait_r == '0, "stop left motion or coils")
  `HSSU_ASSERT_NXT(a_stage_holds, s1_valid_r && !out_load, s1_valid_r && $stable(s1_beats_r) && $stable(s1_req_r), "stalled stage 1 lost its transaction")
  `HSSU_ASSERT_NXT(a_phase_moves_on_step, s1_adv && stepped_nxt, phase_r == $past(phase_r) + PHASE_W'(1), "step without phase advance")

endmodule

// ===== test/half_step_stepper_sequencer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// half_step_stepper_sequencer_unit_tb
// Self-checking bench for the half-step stepper sequencer. A directed table
// covers reset state, extremes, invalid directions, stop and idle requests;
// random move-and-tick sequences follow. Every result is compared field by
// field against its row's own expected value or an in-bench sequencer model,
// under random sender bursts and receiver stalls, including one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module half_step_stepper_sequencer_unit_tb;
  import hssu_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 8;
  localparam int ITEM_TARGET  = 1200;
  localparam int HOLD_ITEMS   = 50;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int NUM_DIRECTED = 25;
  localparam longint unsigned BEAT_CAP = (64'd1 << BEAT_W) - 1;

  typedef struct packed {
    logic [COIL_W-1:0] coils;
    logic              stepped;
    logic              busy;
  } coil_result_t;

  // one transaction; typed rows carry their own expected result
  typedef struct packed {
    req_t                         req;
    dir_t                         dir;
    logic [DELAY_W-1:0]           delay;
    logic signed [ANGLE_BITS-1:0] angle;
    logic                         single;
    logic                         typed;
    coil_result_t                 want;
  } stim_row_t;

  localparam coil_result_t COILS_IDLE = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COIL_W-1:0] out_coil_lines;
  logic out_stepped;
  logic out_busy_res;
  stim_row_t cur_row = '0;

  // sequencer model state
  logic [PHASE_W-1:0] phase_pos = '0;
  logic [BEAT_W-1:0]  beats_pending = '0;
  logic [DELAY_W-1:0] wait_ticks = '0;
  logic [DELAY_W-1:0] step_gap = '0;
  logic               rollback = 1'b0;
  logic [COIL_W-1:0]  coil_state = '0;

  logic [COIL_W-1:0] fwd_coils [8] = '{4'h7, 4'h3, 4'hB, 4'h9, 4'hD, 4'hC, 4'hE, 4'h6};
  logic [COIL_W-1:0] rev_coils [8] = '{4'h6, 4'hE, 4'hC, 4'hD, 4'h9, 4'hB, 4'h3, 4'h7};

  coil_result_t coil_q [$];
  coil_result_t predicted;
  coil_result_t oldest;
  int fail_count = 0;
  int sent_count = 0;
  int burst_left = 0;
  int cycle_count = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int stall_mode = 0;
  int stall_span = 0;

  // directed table: req, dir, delay, angle, single, typed, expected
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{REQ_TICK, DIR_NONE_LO, 8'h00, 16'sh0000, 1'b0, 1'b1, '{4'h0, 1'b0, 1'b0}},
    '{REQ_NOP,  DIR_NONE_HI, 8'hFF, 16'sh7FFF, 1'b1, 1'b1, '{4'h0, 1'b0, 1'b0}},
    '{REQ_STOP, DIR_NONE_LO, 8'h00, 16'sh0000, 1'b0, 1'b1, '{4'h0, 1'b0, 1'b0}},
    '{REQ_MOVE, DIR_FWD,     8'h00, 16'sh0000, 1'b1, 1'b1, '{4'h0, 1'b0, 1'b1}},
    '{REQ_TICK, DIR_NONE_LO, 8'h00, 16'sh0000, 1'b0, 1'b1, '{4'h3, 1'b1, 1'b0}},
    '{REQ_MOVE, DIR_REV,     8'hFF, 16'sh0001, 1'b0, 1'b0, COILS_IDLE},
    '{REQ_TICK, DIR_NONE_LO, 8'h00, 16'sh0000, 1'b0, 1'b0, COILS_IDLE},
    '{REQ_TICK, DIR_NONE_HI, 8'hFF, 16'shFFFF, 1'b1, 1'b0, COILS_IDLE},
    '{REQ_MOVE, DIR_NONE_LO, 8'h10, 16'sh7FFF, 1'b0, 1'b0, COILS_IDLE},
    '{REQ_MOVE, DIR_NONE_HI, 8'h20, 16'sh8000, 1'b1, 1'b0, COILS_IDLE},
    '{REQ_MOVE, DIR_FWD,     8'h01, 16'sh8000, 1'b0, 1'b0, COILS_IDLE},
    '{REQ_TICK, DIR_NONE_LO, 8'h00, 16'sh0000, 1'b0, 1'b0, COILS_IDLE},
    '{REQ_TICK, DIR_NONE_LO, 8'h00, 16'sh0000, 1'b0, 1'b0, COILS_IDLE},
    '{REQ_TICK, DIR_NONE_LO, 8'h00, 16'sh0000, 1'b0, 1'b0, COILS_IDLE},
    '{REQ_STOP, DIR_NONE_HI, 8'hFF, 16'shFFFF, 1'b1, 1'b1, '{4'h0, 1'b0, 1'b0}},
    '{REQ_MOVE, DIR_FWD,     8'h03, 16'sh0000, 1'b0, 1'b0, COILS_IDLE},
    '{REQ_TICK, DIR_NONE_LO, 8'h00, 16'sh0000, 1'b0, 1'b0, COILS_IDLE},
    '{REQ_MOVE, DIR_REV,     8'h02, 16'shFFFF, 1'b0, 1'b0, COILS_IDLE},
    '{REQ_TICK, DIR_NONE_LO, 8'h00, 16'sh0000, 1'b0, 1'b0, COILS_IDLE},
    '{REQ_TICK, DIR_NONE_LO, 8'h00, 16'sh0000, 1'b0, 1'b0, COILS_IDLE},
    '{REQ_MOVE, DIR_FWD,     8'h00, 16'sh1234, 1'b1, 1'b0, COILS_IDLE},
    '{REQ_TICK, DIR_NONE_LO, 8'h00, 16'sh0000, 1'b0, 1'b0, COILS_IDLE},
    '{REQ_NOP,  DIR_FWD,     8'h5A, 16'sh5A5A, 1'b0, 1'b0, COILS_IDLE},
    '{REQ_MOVE, DIR_FWD,     8'h80, 16'sh7FFF, 1'b0, 1'b0, COILS_IDLE},
    '{REQ_TICK, DIR_NONE_LO, 8'h00, 16'sh0000, 1'b0, 1'b0, COILS_IDLE}
  };

  half_step_stepper_sequencer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (cur_row.req),
    .in_direction_code (cur_row.dir),
    .in_step_delay     (cur_row.delay),
    .in_angle_degrees  (cur_row.angle),
    .in_single_step    (cur_row.single),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_coil_lines    (out_coil_lines),
    .out_stepped       (out_stepped),
    .out_busy_res      (out_busy_res)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // advance the sequencer model by one transaction and return its result
  function automatic coil_result_t advance_sequencer(input stim_row_t r);
    logic [ANGLE_BITS-1:0] raw;
    longint unsigned mag;
    longint unsigned count;
    coil_result_t res;
    res = '0;
    case (r.req)
      REQ_MOVE: begin
        raw = r.angle;
        if (raw[ANGLE_BITS-1]) mag = (64'd1 << ANGLE_BITS) - 64'(raw);
        else mag = 64'(raw);
        count = mag * BEATS_PER_REV / DEGREES_PER_REV;
        if (count > BEAT_CAP) count = BEAT_CAP;
        if (r.single) count = 1;
        wait_ticks = '0;
        if (r.dir == DIR_FWD || r.dir == DIR_REV) begin
          beats_pending = BEAT_W'(count);
          step_gap = r.delay;
          rollback = (r.dir == DIR_REV);
        end else begin
          beats_pending = '0;
        end
      end
      REQ_TICK: begin
        if (wait_ticks != 0) wait_ticks = wait_ticks - 1'b1;
        if (wait_ticks == 0 && beats_pending != 0) begin
          phase_pos = phase_pos + 1'b1;
          coil_state = rollback ? rev_coils[phase_pos] : fwd_coils[phase_pos];
          beats_pending = beats_pending - 1'b1;
          wait_ticks = step_gap;
          res.stepped = 1'b1;
        end
      end
      REQ_STOP: begin
        beats_pending = '0;
        wait_ticks = '0;
        coil_state = '0;
      end
      default: ;
    endcase
    res.coils = coil_state;
    res.busy = (beats_pending != 0) || (wait_ticks != 0);
    return res;
  endfunction

  function automatic stim_row_t make_row(input req_t req, input dir_t dir,
                                         input logic [DELAY_W-1:0] delay,
                                         input logic signed [ANGLE_BITS-1:0] angle,
                                         input logic single);
    stim_row_t r;
    r = '0;
    r.req = req;
    r.dir = dir;
    r.delay = delay;
    r.angle = angle;
    r.single = single;
    return r;
  endfunction

  // non-move transaction; its move fields are don't-care, so fully random
  function automatic stim_row_t noise_row(input req_t req);
    return make_row(req, dir_t'($urandom_range(0, 3)), DELAY_W'($urandom),
                    ANGLE_BITS'($urandom), 1'($urandom));
  endfunction

  // mostly short waits, sometimes the full range
  function automatic logic [DELAY_W-1:0] pick_delay();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return DELAY_W'($urandom_range(0, 1));
    if (sel < 85) return DELAY_W'($urandom_range(2, 4));
    return DELAY_W'($urandom_range(0, 255));
  endfunction

  // mostly small angles so moves finish, with full-range and extreme values
  function automatic logic signed [ANGLE_BITS-1:0] pick_angle();
    int unsigned sel;
    logic signed [ANGLE_BITS-1:0] ang;
    sel = $urandom_range(0, 99);
    if (sel < 50) ang = ANGLE_BITS'($urandom_range(0, 4));
    else if (sel < 80) ang = ANGLE_BITS'($urandom_range(0, 40));
    else if (sel < 95) ang = ANGLE_BITS'($urandom);
    else ang = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7FFF;
    if (sel < 80 && $urandom_range(0, 1) != 0) ang = -ang;
    return ang;
  endfunction

  // offer one transaction until accepted, then maybe open a gap
  task automatic send_row(input stim_row_t r, input bit gapless);
    in_valid <= 1'b1;
    cur_row <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (!gapless) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  // predict on each accepted transaction, check each accepted result
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predicted = advance_sequencer(cur_row);
      coil_q.push_back(cur_row.typed ? cur_row.want : predicted);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (coil_q.size() == 0) begin
        $error("result with no transaction pending: coil_lines=%h", out_coil_lines);
        fail_count++;
      end else begin
        oldest = coil_q.pop_front();
        if (out_coil_lines !== oldest.coils) begin
          $error("coil_lines: expected %h, got %h", oldest.coils, out_coil_lines);
          fail_count++;
        end
        if (out_stepped !== oldest.stepped) begin
          $error("stepped: expected %b, got %b", oldest.stepped, out_stepped);
          fail_count++;
        end
        if (out_busy_res !== oldest.busy) begin
          $error("busy_res: expected %b, got %b", oldest.busy, out_busy_res);
          fail_count++;
        end
      end
    end
  end

  // receiver: one long hold-off on request, otherwise changing stall patterns
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      if (stall_span == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_span <= $urandom_range(20, 200);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned run_len;
    dir_t dir;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < NUM_DIRECTED; i++) send_row(directed_rows[i], 1'b0);

    // output held off while input keeps offering, so the block backs up
    hold_req <= 1'b1;
    send_row(make_row(REQ_MOVE, DIR_FWD, 8'h00, 16'sh0014, 1'b0), 1'b1);
    repeat (HOLD_ITEMS) send_row(noise_row(REQ_TICK), 1'b1);

    // random part: a move followed by a run of ticks, with stops and noise
    while (sent_count < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) dir = ($urandom_range(0, 1) != 0) ? DIR_FWD : DIR_REV;
      else if (pick < 90) dir = DIR_NONE_LO;
      else dir = DIR_NONE_HI;
      send_row(make_row(REQ_MOVE, dir, pick_delay(), pick_angle(),
                        $urandom_range(0, 3) == 0), 1'b0);
      run_len = $urandom_range(2, 60);
      repeat (run_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 90) send_row(noise_row(REQ_TICK), 1'b0);
        else if (pick < 94) send_row(noise_row(REQ_STOP), 1'b0);
        else if (pick < 97) send_row(noise_row(REQ_NOP), 1'b0);
        else send_row(make_row(REQ_MOVE, dir_t'($urandom_range(0, 3)), pick_delay(),
                               pick_angle(), 1'($urandom)), 1'b0);
      end
    end
    in_valid <= 1'b0;

    // drain outstanding results, then watch for strays
    while (coil_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== half_step_stepper_sequencer_unit.f =====
+incdir+sv
sv/hssu_pkg.sv
sv/hssu_beat_calc.sv
sv/half_step_stepper_sequencer_unit.sv
test/half_step_stepper_sequencer_unit_tb.sv
